[rtl/pfdm_pkg.sv]
// Package for the PWM frequency/duty measure core: payload types, widths, codes.
// No dependencies.
package pfdm_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned ClkWidth   = 27;
  localparam int unsigned ScaleWidth = 10;
  localparam int unsigned FreqWidth  = 16;
  localparam int unsigned PerWidth   = CountWidth + 1;
  localparam int unsigned NumWidth   = 27;  // max(ClkWidth, PerWidth + ScaleWidth)
  localparam int unsigned QuoWidth   = NumWidth;
  localparam logic [FreqWidth-1:0] FreqMax = '1;

  localparam logic OpCapture  = 1'b0;
  localparam logic OpOverflow = 1'b1;

  localparam logic [0:0] RegClockHz   = 1'b0;
  localparam logic [0:0] RegDutyScale = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [CountWidth-1:0] period_count;
    logic [CountWidth-1:0] high_count;
  } in_item_t;

  typedef struct packed {
    logic [FreqWidth-1:0]  frequency;
    logic [ScaleWidth-1:0] duty;
    logic                  valid_res;
  } out_item_t;

  // Control flags traveling alongside a divide pipeline.
  typedef struct packed {
    logic valid;
    logic capture;
  } pipe_ctl_t;

endpackage

[rtl/pfdm_div.sv]
// Pipelined restoring divider: one quotient bit per stage, stalls as a whole.
// Depends on pfdm_pkg.
module pfdm_div
  import pfdm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [PerWidth-1:0] den_i,
  output logic                valid_o,
  output logic [QuoWidth-1:0] quo_o
);

  localparam int unsigned Stages = NumWidth;

  logic [Stages:0]               vld_q;
  logic [NumWidth-1:0]           num_q [Stages+1];
  logic [PerWidth-1:0]           den_q [Stages+1];
  logic [PerWidth-1:0]           rem_q [Stages+1];

  assign num_q[0] = num_i;
  assign den_q[0] = den_i;
  assign rem_q[0] = '0;
  assign vld_q[0] = valid_i;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [PerWidth:0]   trial;
    logic [PerWidth:0]   diff;
    logic                ge;
    logic [NumWidth-1:0] num_d;
    logic [PerWidth-1:0] rem_d;
    always_comb begin
      trial = {rem_q[s], num_q[s][NumWidth-1]};
      diff  = trial - {1'b0, den_q[s]};
      ge    = ~diff[PerWidth];
      rem_d = ge ? diff[PerWidth-1:0] : trial[PerWidth-1:0];
      num_d = {num_q[s][NumWidth-2:0], ge};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        num_q[s+1] <= num_d;
        rem_q[s+1] <= rem_d;
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign valid_o = vld_q[Stages];
  assign quo_o   = num_q[Stages];

endmodule

[rtl/pwm_frequency_duty_measure_core.sv]
// Top level of the PWM frequency/duty measure core: APB registers, front stage,
// two pfdm_div pipelines, saturation and output register. Depends on pfdm_pkg.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o | in_item_t
//  out     | output    | out_valid_o/out_stall_i | out_item_t
//  cfg     | input     | APB psel/penable      | clock_hz, duty_scale
//
// Pipeline: 1 front stage, 27 divider stages and 1 output stage.
// One item per cycle unless stalled; the divider depth (one bit per stage) sets latency.
// The whole pipeline advances together; a stall at the output freezes every stage
// once the output register is full, so nothing is lost or repeated.
// Reset clears the valid bits and restores clock_hz=1000000, duty_scale=1000.
module pwm_frequency_duty_measure_core
  import pfdm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ClkWidth-1:0]   clock_hz_q;
  logic [ScaleWidth-1:0] duty_scale_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q   <= ClkWidth'(1000000);
      duty_scale_q <= ScaleWidth'(1000);
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegClockHz:   clock_hz_q   <= pwdata[ClkWidth-1:0];
        RegDutyScale: duty_scale_q <= pwdata[ScaleWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegClockHz:   prdata = {{(32-ClkWidth){1'b0}}, clock_hz_q};
      RegDutyScale: prdata = {{(32-ScaleWidth){1'b0}}, duty_scale_q};
      default:      prdata = '0;
    endcase
  end

  // Pipeline advances unless the output register holds an unaccepted item.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Front stage: add one to the counts and form the duty numerator.
  pipe_ctl_t           f_ctl_q;
  logic [PerWidth-1:0] f_per_q;
  logic [PerWidth-1:0] f_high_q;
  logic [ScaleWidth-1:0] f_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_ctl_q <= '0;
    end else if (adv) begin
      f_ctl_q.valid   <= in_valid_i;
      f_ctl_q.capture <= (in_item_i.op == OpCapture);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_per_q   <= {1'b0, in_item_i.period_count} + PerWidth'(1);
      f_high_q  <= {1'b0, in_item_i.high_count} + PerWidth'(1);
      f_scale_q <= duty_scale_q;
    end
  end

  logic [NumWidth-1:0] duty_num;
  assign duty_num = NumWidth'(f_high_q) * NumWidth'(f_scale_q);

  // Control, scale travel in a shift line matching divider depth.
  localparam int unsigned Depth = NumWidth;
  pipe_ctl_t             ctl_q   [Depth];
  logic [ScaleWidth-1:0] scale_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) ctl_q[i] <= '0;
    end else if (adv) begin
      ctl_q[0] <= f_ctl_q;
      for (int i = 1; i < Depth; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      scale_q[0] <= f_scale_q;
      for (int i = 1; i < Depth; i++) scale_q[i] <= scale_q[i-1];
    end
  end

  logic                fq_vld, dq_vld;
  logic [QuoWidth-1:0] fq, dq;

  pfdm_div u_div_freq (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(f_ctl_q.valid),
    .num_i(clock_hz_q), .den_i(f_per_q), .valid_o(fq_vld), .quo_o(fq)
  );

  pfdm_div u_div_duty (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(f_ctl_q.valid),
    .num_i(duty_num), .den_i(f_per_q), .valid_o(dq_vld), .quo_o(dq)
  );

  // Saturate and register the result.
  pipe_ctl_t             t_ctl;
  logic [ScaleWidth-1:0] t_scale;
  logic [FreqWidth-1:0]  freq_sat;
  logic [ScaleWidth-1:0] duty_sat;
  out_item_t             res_d;
  logic                  out_valid_q;
  out_item_t             out_item_q;

  always_comb begin
    t_ctl    = ctl_q[Depth-1];
    t_scale  = scale_q[Depth-1];
    freq_sat = (fq > QuoWidth'(FreqMax)) ? FreqMax : fq[FreqWidth-1:0];
    duty_sat = (dq > QuoWidth'(t_scale)) ? t_scale : dq[ScaleWidth-1:0];
    if (t_ctl.capture) begin
      res_d = '{frequency: freq_sat, duty: duty_sat, valid_res: 1'b1};
    end else begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= t_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Control shift line and both dividers must agree on item position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_vld == t_ctl.valid) else $error("freq divider out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq_vld == fq_vld) else $error("dividers out of step");
  // Duty never exceeds full scale; frequency never exceeds the tick rate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.valid_res |-> out_item_o.duty <= duty_scale_q
      && ClkWidth'(out_item_o.frequency) <= clock_hz_q)
    else $error("result out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.valid_res |-> out_item_o.frequency == 0 && out_item_o.duty == 0)
    else $error("cleared result carries data");

endmodule

[bench/pwm_frequency_duty_measure_core_tb.sv]
// Testbench for pwm_frequency_duty_measure_core: directed table plus random items,
// checked against an in-bench frequency/duty predictor. Depends on pfdm_pkg and the RTL.
`timescale 1ns / 100ps

module pwm_frequency_duty_measure_core_tb;
  import pfdm_pkg::*;

  localparam int unsigned NumRandom   = 1030;
  localparam int unsigned Latency     = 29;
  localparam int unsigned WatchdogMax = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pwm_frequency_duty_measure_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Directed row: expected result given only where it is obvious.
  typedef struct {
    in_item_t  item;
    logic      has_exp;
    out_item_t exp;
  } capture_row_t;

  // Predictor copy of registers and stored measurement.
  logic [ClkWidth-1:0]   clock_hz_q;
  logic [ScaleWidth-1:0] duty_scale_q;
  out_item_t             measure_q;

  out_item_t  expected_meas[$];
  int unsigned mismatch_cnt;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned idle_cycles;
  logic        timed_out;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Frequency/duty computed on wide integers, then saturated; an overflow clears the result.
  function automatic out_item_t measure_event(in_item_t it);
    longint unsigned period;
    longint unsigned high;
    longint unsigned freq;
    longint unsigned dut;
    out_item_t r;
    if (it.op == OpOverflow) begin
      measure_q = '0;
    end else begin
      period = longint'(it.period_count) + 1;
      high   = longint'(it.high_count) + 1;
      freq   = longint'(clock_hz_q) / period;
      dut    = (high * longint'(duty_scale_q)) / period;
      if (freq > 65535) freq = 65535;
      if (dut > duty_scale_q) dut = duty_scale_q;
      measure_q.frequency = freq[FreqWidth-1:0];
      measure_q.duty      = dut[ScaleWidth-1:0];
      measure_q.valid_res = 1'b1;
    end
    r = measure_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH result %0d %s: got %0d want %0d", results_seen, what, got, want);
    mismatch_cnt++;
  endtask

  // Output side: pseudo-random stall pattern, checks at rising edge.
  int unsigned stall_mode;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_meas.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        out_item_t e;
        e = expected_meas.pop_front();
        if (out_item_o.frequency !== e.frequency)
          report_mismatch("frequency", out_item_o.frequency, e.frequency);
        if (out_item_o.duty !== e.duty)
          report_mismatch("duty", out_item_o.duty, e.duty);
        if (out_item_o.valid_res !== e.valid_res)
          report_mismatch("valid_res", out_item_o.valid_res, e.valid_res);
      end
      results_seen++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      // Modes: no stall, light stall, heavy stall, periodic.
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 7) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // Watchdog: cycles with no handshake on either channel and no APB select.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogMax && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // APB write: setup then access; pready is always high.
  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= idx;
    pwdata  <= val;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegClockHz) clock_hz_q = val[ClkWidth-1:0];
    else duty_scale_q = val[ScaleWidth-1:0];
  endtask

  // Drive one item; stays on the bus until accepted. Prediction is pushed on accept.
  task automatic send_item(in_item_t it);
    out_item_t e;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    e = measure_event(it);
    expected_meas.push_back(e);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Sender bursts: after each burst of items, maybe a random gap with valid low.
  int unsigned burst_left;
  task automatic send_paced(in_item_t it);
    int unsigned gap;
    send_item(it);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        in_item_i  <= '0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (expected_meas.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  function automatic in_item_t rand_capture();
    in_item_t it;
    int unsigned kind;
    it.op = OpCapture;
    kind = $urandom_range(0, 3);
    // Mostly high time within the period, sometimes beyond it; some periods are short.
    it.period_count = (kind == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
    if (kind == 3) it.high_count = 16'($urandom);
    else it.high_count = 16'($urandom_range(0, it.period_count));
    return it;
  endfunction

  capture_row_t dir_rows[$];

  function automatic capture_row_t mk_row(logic op, logic [15:0] p, logic [15:0] h,
                                          logic has, logic [15:0] f, logic [9:0] d,
                                          logic v);
    capture_row_t r;
    r.item.op           = op;
    r.item.period_count = p;
    r.item.high_count   = h;
    r.has_exp           = has;
    r.exp.frequency     = f;
    r.exp.duty          = d;
    r.exp.valid_res     = v;
    return r;
  endfunction

  initial begin
    in_item_t  it;
    out_item_t e;
    logic [31:0] clk_set[4];
    logic [31:0] scale_set[4];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    stall_mode  = 0;
    burst_left  = 0;
    mismatch_cnt = 0;
    items_sent   = 0;
    results_seen = 0;
    idle_cycles  = 0;
    timed_out    = 1'b0;
    clock_hz_q   = 27'd1000000;
    duty_scale_q = 10'd1000;
    measure_q    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at reset settings (1 MHz tick, scale 1000).
    // Overflow right after reset: all zero.
    dir_rows.push_back(mk_row(OpOverflow, 16'h0, 16'h0, 1'b1, 16'd0, 10'd0, 1'b0));
    // Period 1 tick: 1 MHz saturates, duty full.
    dir_rows.push_back(mk_row(OpCapture, 16'h0, 16'h0, 1'b1, 16'hFFFF, 10'd1000, 1'b1));
    // Max period, min high: 1e6/65536 = 15, duty 1000/65536 = 0.
    dir_rows.push_back(mk_row(OpCapture, 16'hFFFF, 16'h0, 1'b1, 16'd15, 10'd0, 1'b1));
    // Max period and high: duty full.
    dir_rows.push_back(mk_row(OpCapture, 16'hFFFF, 16'hFFFF, 1'b1, 16'd15, 10'd1000, 1'b1));
    // High longer than period saturates duty.
    dir_rows.push_back(mk_row(OpCapture, 16'd999, 16'hFFFF, 1'b1, 16'd1000, 10'd1000, 1'b1));
    // Half duty at 1 kHz.
    dir_rows.push_back(mk_row(OpCapture, 16'd999, 16'd499, 1'b1, 16'd1000, 10'd500, 1'b1));
    // Overflow clears; overflow ignores its count fields.
    dir_rows.push_back(mk_row(OpOverflow, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 10'd0, 1'b0));
    dir_rows.push_back(mk_row(OpCapture, 16'hAAAA, 16'h5555, 1'b0, 16'd0, 10'd0, 1'b0));
    dir_rows.push_back(mk_row(OpCapture, 16'h5555, 16'hAAAA, 1'b0, 16'd0, 10'd0, 1'b0));
    dir_rows.push_back(mk_row(OpCapture, 16'd14, 16'd3, 1'b0, 16'd0, 10'd0, 1'b0));
    dir_rows.push_back(mk_row(OpOverflow, 16'h0, 16'h0, 1'b1, 16'd0, 10'd0, 1'b0));
    dir_rows.push_back(mk_row(OpOverflow, 16'h1234, 16'h4321, 1'b1, 16'd0, 10'd0, 1'b0));
    foreach (dir_rows[i]) begin
      send_paced(dir_rows[i].item);
      if (dir_rows[i].has_exp) begin
        e = expected_meas[expected_meas.size() - 1];
        if (e != dir_rows[i].exp)
          report_mismatch("table entry", i, 0);
      end
    end
    drain_pipe();

    // Register extremes: zero clock and zero scale, then the maximum values.
    reg_write(RegClockHz, 32'd0);
    reg_write(RegDutyScale, 32'd0);
    send_paced('{op: OpCapture, period_count: 16'd9, high_count: 16'd4});
    send_paced('{op: OpCapture, period_count: 16'h0, high_count: 16'hFFFF});
    send_paced('{op: OpOverflow, period_count: 16'h0, high_count: 16'h0});
    drain_pipe();
    reg_write(RegClockHz, 32'h07FF_FFFF);
    reg_write(RegDutyScale, 32'h3FF);
    send_paced('{op: OpCapture, period_count: 16'hFFFF, high_count: 16'h7FFF});
    send_paced('{op: OpCapture, period_count: 16'd2047, high_count: 16'd2047});
    send_paced('{op: OpCapture, period_count: 16'h0, high_count: 16'h1});
    drain_pipe();

    // Random phases across several register settings.
    clk_set   = '{32'd100000000, 32'd1, 32'd1000000, 32'($urandom_range(1, 100000000))};
    scale_set = '{32'd1000, 32'd1, 32'd100, 32'($urandom_range(1, 1000))};
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(RegClockHz, clk_set[ph]);
      reg_write(RegDutyScale, scale_set[ph]);
      for (int n = 0; n < NumRandom / 4; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          it.op           = OpOverflow;
          it.period_count = 16'($urandom);
          it.high_count   = 16'($urandom);
        end else begin
          it = rand_capture();
        end
        send_paced(it);
      end
      drain_pipe();
    end

    $display("Covered %0d items, %0d results, over seven register settings incl. extremes.",
             items_sent, results_seen);
    $display("Captures hit saturation of frequency and duty plus overflow clears.");
    if (mismatch_cnt == 0 && expected_meas.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results left over", mismatch_cnt, expected_meas.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
